[hdl/tls_client_hello_sni_extractor_defines.svh]
// assertion macros for the tls sni extractor
// used by modules that check their own logic; needs i_clk and i_rst_n in scope
`ifndef TLS_CLIENT_HELLO_SNI_EXTRACTOR_DEFINES_SVH
`define TLS_CLIENT_HELLO_SNI_EXTRACTOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TLSSNI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define TLSSNI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/tlssni_pkg.sv]
// shared constants and types of the tls sni extractor
// no dependencies
`default_nettype none
package tlssni_pkg;
    localparam int NAME_MAX_DEF = 256;

    // verdict status codes
    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_NONE     = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    // verdict handed from parser to emitter
    typedef struct packed {
        logic       bank;
        logic [1:0] status;
    } t_verdict;
endpackage
`default_nettype wire

[hdl/tlssni_ifs.sv]
// byte input and chunk output channel interfaces
// no dependencies
`default_nettype none
interface tlssni_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;
    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface tlssni_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] name_chunk;
    logic [3:0]  chunk_bytes;
    logic [1:0]  status;
    logic        last_chunk;
    modport source (output valid, output name_chunk, output chunk_bytes, output status,
                    output last_chunk, input ready);
    modport sink (input valid, input name_chunk, input chunk_bytes, input status,
                  input last_chunk, output ready);
endinterface
`default_nettype wire

[hdl/tlssni_name_ram.sv]
// two-bank hostname store, 8 bytes per word, byte-lane write, registered read
// depends on nothing but its parameters
`default_nettype none
module tlssni_name_ram #(
    parameter int AW = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW:0]   i_waddr,
    input  wire logic [2:0]    i_wlane,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW:0]   i_raddr,
    output logic      [63:0]   o_rdata
);
    localparam int Depth = 2 ** (AW + 1);

    logic [63:0] r_mem [Depth];
    logic [63:0] r_rdata;

    // byte write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr][{i_wlane, 3'b000} +: 8] <= i_wdata;
        end
    end

    // word read, held between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

[hdl/tlssni_parser.sv]
// record / handshake / extension walker, one byte per cycle while no unaccepted verdict holds the input
// depends on tlssni_pkg and tlssni_in_if; writes the name store
`default_nettype none
module tlssni_parser #(
    parameter int NAME_MAX = tlssni_pkg::NAME_MAX_DEF,
    parameter int AW       = 5,
    parameter int LW       = 9
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    tlssni_in_if.sink                 i_byte,
    input  wire logic                 i_take,
    output logic                      o_vld,
    output tlssni_pkg::t_verdict      o_verdict,
    output logic      [LW-1:0]        o_len,
    output logic                      o_we,
    output logic      [AW:0]          o_waddr,
    output logic      [2:0]           o_wlane,
    output logic      [7:0]           o_wdata
);
    localparam logic [15:0] NameMaxW = 16'(NAME_MAX);

    typedef enum logic [4:0] {
        PH_REC_HDR, PH_HS_HDR, PH_FIXED, PH_SID_LEN, PH_SID_SKIP, PH_CS_LEN,
        PH_CS_SKIP, PH_CM_LEN, PH_CM_SKIP, PH_EXTS_LEN, PH_EXT_HDR, PH_EXT_SKIP,
        PH_SNI_LIST_LEN, PH_SNI_ENTRY_HDR, PH_SNI_NAME, PH_SNI_ENTRY_SKIP,
        PH_SNI_REST, PH_DONE
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [14:0]   r_seen, n_seen;
    logic [15:0]   r_rec_len, n_rec_len;
    logic [23:0]   r_body_len, n_body_len;
    logic [23:0]   r_body_off, n_body_off;
    logic [31:0]   r_field, n_field;
    logic [15:0]   r_frem, n_frem;
    logic [15:0]   r_ext_rem, n_ext_rem;
    logic [15:0]   r_sni_ext, n_sni_ext;
    logic [15:0]   r_sni_list, n_sni_list;
    logic [15:0]   r_name_len, n_name_len;
    logic          r_chars_ok, n_chars_ok;
    logic          r_failed, n_failed;
    logic          r_found, n_found;
    logic          r_too_long, n_too_long;
    logic [LW-1:0] r_found_len, n_found_len;
    logic          r_bank, n_bank;
    logic          r_vld, n_vld;
    tlssni_pkg::t_verdict r_verdict, n_verdict;
    logic [LW-1:0] r_len, n_len;

    logic        accept;
    logic [7:0]  b;
    logic        done_f, do_sni_loop, do_skip_rest, do_ext_loop, stop, char_ok, complete;
    logic [15:0] fv, elen, er, pos, s;
    logic [15:0] rl;

    assign accept = i_byte.valid && i_byte.ready;
    assign i_byte.ready = !r_vld || i_take;
    assign b = i_byte.byte_value;

    // next-state of the walker for one accepted byte
    always_comb begin
        n_phase = r_phase;         n_seen = r_seen;         n_rec_len = r_rec_len;
        n_body_len = r_body_len;   n_body_off = r_body_off; n_field = r_field;
        n_frem = r_frem;           n_ext_rem = r_ext_rem;   n_sni_ext = r_sni_ext;
        n_sni_list = r_sni_list;   n_name_len = r_name_len; n_chars_ok = r_chars_ok;
        n_failed = r_failed;       n_found = r_found;       n_too_long = r_too_long;
        n_found_len = r_found_len; n_bank = r_bank;
        n_vld = r_vld && !i_take;  n_verdict = r_verdict;   n_len = r_len;
        o_we = 1'b0; o_wdata = 8'd0;
        done_f = 1'b0; do_sni_loop = 1'b0; do_skip_rest = 1'b0; do_ext_loop = 1'b0;
        stop = 1'b0; char_ok = 1'b0; complete = 1'b0;
        fv = 16'd0; elen = 16'd0; er = 16'd0; s = 16'd0; rl = 16'd0;
        pos = r_name_len - r_frem;
        o_waddr = {r_bank, pos[AW+2:3]};
        o_wlane = pos[2:0];
        if (accept) begin
            // body bound check from the fixed ClientHello part up to the extensions length
            if (r_phase inside {PH_FIXED, PH_SID_LEN, PH_SID_SKIP, PH_CS_LEN, PH_CS_SKIP,
                                PH_CM_LEN, PH_CM_SKIP, PH_EXTS_LEN}) begin
                if (r_body_off >= r_body_len) begin
                    n_failed = 1'b1;
                    n_phase = PH_DONE;
                    stop = 1'b1;
                end else begin
                    n_body_off = r_body_off + 24'd1;
                end
            end
            // sni extension and list byte budgets
            if (r_phase inside {PH_SNI_LIST_LEN, PH_SNI_ENTRY_HDR, PH_SNI_NAME,
                                PH_SNI_ENTRY_SKIP, PH_SNI_REST}) begin
                if (r_sni_ext != 16'd0) n_sni_ext = r_sni_ext - 16'd1;
                if (r_sni_list != 16'd0) n_sni_list = r_sni_list - 16'd1;
            end
            // field collector and down counter
            if (r_frem != 16'd0) n_frem = r_frem - 16'd1;
            done_f = (n_frem == 16'd0);
            if (r_phase inside {PH_CS_LEN, PH_EXTS_LEN, PH_EXT_HDR, PH_SNI_LIST_LEN,
                                PH_SNI_ENTRY_HDR}) begin
                n_field = {r_field[23:0], b};
            end
            fv = n_field[15:0];
            if (!stop) begin
                case (r_phase)
                    PH_REC_HDR: begin
                        if (r_seen == 15'd0) begin
                            if (b != 8'd22) begin n_failed = 1'b1; n_phase = PH_DONE; end
                        end else if (r_seen == 15'd1) begin
                            if (b != 8'd3) begin n_failed = 1'b1; n_phase = PH_DONE; end
                        end else if (r_seen == 15'd2) begin
                            if (b > 8'd4) begin n_failed = 1'b1; n_phase = PH_DONE; end
                        end else if (r_seen == 15'd3) begin
                            n_rec_len = {b, 8'd0};
                        end else begin
                            rl = {r_rec_len[15:8], b};
                            n_rec_len = rl;
                            if (rl < 16'd4 || rl > 16'd16384) begin
                                n_failed = 1'b1; n_phase = PH_DONE;
                            end else begin
                                n_phase = PH_HS_HDR;
                            end
                        end
                    end
                    PH_HS_HDR: begin
                        if (r_seen == 15'd5) begin
                            if (b != 8'd1) begin n_failed = 1'b1; n_phase = PH_DONE; end
                        end else begin
                            n_body_len = {r_body_len[15:0], b};
                            if (r_seen >= 15'd8) begin
                                if ({1'b0, n_body_len} + 25'd4 > {9'd0, r_rec_len}
                                    || n_body_len < 24'd34) begin
                                    n_failed = 1'b1; n_phase = PH_DONE;
                                end else begin
                                    n_body_off = 24'd0; n_phase = PH_FIXED;
                                    n_frem = 16'd34; n_field = 32'd0;
                                end
                            end
                        end
                    end
                    PH_FIXED: if (done_f) n_phase = PH_SID_LEN;
                    PH_SID_LEN: begin
                        n_field = 32'd0;
                        if (b == 8'd0) begin n_phase = PH_CS_LEN; n_frem = 16'd2; end
                        else begin n_phase = PH_SID_SKIP; n_frem = {8'd0, b}; end
                    end
                    PH_SID_SKIP: if (done_f) begin
                        n_phase = PH_CS_LEN; n_frem = 16'd2; n_field = 32'd0;
                    end
                    PH_CS_LEN: if (done_f) begin
                        n_field = 32'd0; n_frem = fv;
                        n_phase = (fv == 16'd0) ? PH_CM_LEN : PH_CS_SKIP;
                    end
                    PH_CS_SKIP: if (done_f) n_phase = PH_CM_LEN;
                    PH_CM_LEN: begin
                        n_field = 32'd0;
                        if (b == 8'd0) begin n_phase = PH_EXTS_LEN; n_frem = 16'd2; end
                        else begin n_phase = PH_CM_SKIP; n_frem = {8'd0, b}; end
                    end
                    PH_CM_SKIP: if (done_f) begin
                        n_phase = PH_EXTS_LEN; n_frem = 16'd2; n_field = 32'd0;
                    end
                    PH_EXTS_LEN: if (done_f) begin
                        if ({1'b0, n_body_off} + {9'd0, fv} > {1'b0, r_body_len}) begin
                            n_failed = 1'b1; n_phase = PH_DONE;
                        end else begin
                            n_ext_rem = fv; do_ext_loop = 1'b1;
                        end
                    end
                    PH_EXT_HDR: if (done_f) begin
                        elen = fv;
                        er = r_ext_rem - 16'd4;
                        n_ext_rem = er;
                        if (elen > er) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_ext_rem = er - elen;
                            if (n_field[31:16] == 16'd0) begin
                                n_sni_ext = elen; n_sni_list = 16'd0;
                                if (elen >= 16'd2) begin
                                    n_phase = PH_SNI_LIST_LEN; n_frem = 16'd2;
                                    n_field = 32'd0;
                                end else begin
                                    do_skip_rest = 1'b1;
                                end
                            end else begin
                                n_phase = PH_EXT_SKIP; n_frem = elen; n_field = 32'd0;
                                if (elen == 16'd0) do_ext_loop = 1'b1;
                            end
                        end
                    end
                    PH_EXT_SKIP: if (done_f) do_ext_loop = 1'b1;
                    PH_SNI_LIST_LEN: if (done_f) begin
                        if (fv > n_sni_ext) do_skip_rest = 1'b1;
                        else begin n_sni_list = fv; do_sni_loop = 1'b1; end
                    end
                    PH_SNI_ENTRY_HDR: if (done_f) begin
                        if (n_field[23:16] == 8'd0) begin
                            if (fv > n_sni_ext) begin
                                do_skip_rest = 1'b1;
                            end else begin
                                n_name_len = fv; n_chars_ok = 1'b1;
                                n_phase = PH_SNI_NAME; n_frem = fv; n_field = 32'd0;
                                if (fv == 16'd0) do_sni_loop = 1'b1;
                            end
                        end else begin
                            s = (fv < n_sni_ext) ? fv : n_sni_ext;
                            n_phase = PH_SNI_ENTRY_SKIP; n_frem = s; n_field = 32'd0;
                            if (s == 16'd0) do_sni_loop = 1'b1;
                        end
                    end
                    PH_SNI_NAME: begin
                        char_ok = (b >= 8'd48 && b <= 8'd57) || (b >= 8'd65 && b <= 8'd90)
                               || (b >= 8'd97 && b <= 8'd122) || b == 8'd45 || b == 8'd46;
                        n_chars_ok = r_chars_ok && char_ok;
                        if (pos < NameMaxW) begin
                            o_we = 1'b1;
                            o_wdata = (b >= 8'd65 && b <= 8'd90) ? b + 8'd32 : b;
                        end
                        if (done_f) begin
                            if (n_chars_ok) begin
                                if (r_name_len > NameMaxW) begin
                                    n_too_long = 1'b1;
                                end else begin
                                    n_found = 1'b1; n_found_len = r_name_len[LW-1:0];
                                end
                                n_phase = PH_DONE;
                            end else begin
                                do_sni_loop = 1'b1;
                            end
                        end
                    end
                    PH_SNI_ENTRY_SKIP: if (done_f) do_sni_loop = 1'b1;
                    PH_SNI_REST: if (n_sni_ext == 16'd0) do_ext_loop = 1'b1;
                    default: ;
                endcase
            end
            // loop re-entry decisions, in nesting order
            if (do_sni_loop) begin
                if (n_sni_ext >= 16'd3 && n_sni_list != 16'd0) begin
                    n_phase = PH_SNI_ENTRY_HDR; n_frem = 16'd3; n_field = 32'd0;
                end else begin
                    do_skip_rest = 1'b1;
                end
            end
            if (do_skip_rest) begin
                if (n_sni_ext != 16'd0) n_phase = PH_SNI_REST;
                else do_ext_loop = 1'b1;
            end
            if (do_ext_loop) begin
                if (n_ext_rem >= 16'd4) begin
                    n_phase = PH_EXT_HDR; n_frem = 16'd4; n_field = 32'd0;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            if (r_seen != 15'h7fff) n_seen = r_seen + 15'd1;
            // packet end: verdict and clear
            if (i_byte.last_byte) begin
                complete = !n_failed && ({2'b0, n_seen} >= {1'b0, n_rec_len} + 17'd5);
                n_vld = 1'b1;
                n_verdict.bank = r_bank;
                n_len = n_found_len;
                if (complete && n_found && n_found_len != '0) begin
                    n_verdict.status = tlssni_pkg::ST_FOUND;
                end else if (complete && n_too_long) begin
                    n_verdict.status = tlssni_pkg::ST_TOO_LONG;
                end else begin
                    n_verdict.status = tlssni_pkg::ST_NONE;
                end
                n_bank = !r_bank;
                n_phase = PH_REC_HDR; n_seen = 15'd0; n_rec_len = 16'd0;
                n_body_len = 24'd0; n_body_off = 24'd0; n_field = 32'd0;
                n_frem = 16'd0; n_ext_rem = 16'd0; n_sni_ext = 16'd0;
                n_sni_list = 16'd0; n_name_len = 16'd0; n_chars_ok = 1'b1;
                n_failed = 1'b0; n_found = 1'b0; n_too_long = 1'b0; n_found_len = '0;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_REC_HDR; r_seen <= 15'd0; r_rec_len <= 16'd0;
            r_body_len <= 24'd0; r_body_off <= 24'd0; r_field <= 32'd0;
            r_frem <= 16'd0; r_ext_rem <= 16'd0; r_sni_ext <= 16'd0;
            r_sni_list <= 16'd0; r_name_len <= 16'd0; r_chars_ok <= 1'b1;
            r_failed <= 1'b0; r_found <= 1'b0; r_too_long <= 1'b0;
            r_found_len <= '0; r_bank <= 1'b0; r_vld <= 1'b0;
        end else begin
            r_phase <= n_phase; r_seen <= n_seen; r_rec_len <= n_rec_len;
            r_body_len <= n_body_len; r_body_off <= n_body_off; r_field <= n_field;
            r_frem <= n_frem; r_ext_rem <= n_ext_rem; r_sni_ext <= n_sni_ext;
            r_sni_list <= n_sni_list; r_name_len <= n_name_len; r_chars_ok <= n_chars_ok;
            r_failed <= n_failed; r_found <= n_found; r_too_long <= n_too_long;
            r_found_len <= n_found_len; r_bank <= n_bank; r_vld <= n_vld;
        end
    end

    // verdict payload
    always_ff @(posedge i_clk) begin
        r_verdict <= n_verdict;
        r_len <= n_len;
    end

    assign o_vld = r_vld;
    assign o_verdict = r_verdict;
    assign o_len = r_len;
endmodule
`default_nettype wire

[hdl/tlssni_emitter.sv]
// reads the stored name word by word and sends verdict and chunk transactions
// depends on tlssni_pkg, tlssni_out_if and the assertion macro header
`default_nettype none
`include "tls_client_hello_sni_extractor_defines.svh"
module tlssni_emitter #(
    parameter int AW = 5,
    parameter int LW = 9
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_vld,
    input  wire tlssni_pkg::t_verdict i_verdict,
    input  wire logic      [LW-1:0]   i_len,
    output logic                      o_take,
    output logic                      o_re,
    output logic      [AW:0]          o_raddr,
    input  wire logic      [63:0]     i_rdata,
    tlssni_out_if.source              o_name
);
    logic          r_busy, r_bank, r_pend, r_rd_last, r_oval;
    logic [LW-1:0] r_rem;
    logic [AW-1:0] r_addr;
    logic [3:0]    r_rd_bytes;
    logic [63:0]   r_chunk;
    logic [3:0]    r_bytes;
    logic [1:0]    r_status;
    logic          r_last;
    logic          out_free, move, issue, last_rd;
    logic [3:0]    rd_n;
    logic [63:0]   masked;

    assign out_free = !r_oval || o_name.ready;
    assign move     = r_pend && out_free;
    assign issue    = r_busy && (!r_pend || move);
    assign o_take   = i_vld && !r_busy && !r_pend && out_free;
    assign last_rd  = (r_rem <= LW'(8));
    assign rd_n     = last_rd ? r_rem[3:0] : 4'd8;
    assign o_re     = issue;
    assign o_raddr  = {r_bank, r_addr};

    // keep only the valid lanes of the read word
    always_comb begin
        for (int l = 0; l < 8; l++) begin
            masked[l*8 +: 8] = (4'(l) < r_rd_bytes) ? i_rdata[l*8 +: 8] : 8'd0;
        end
    end

    // read sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_pend <= 1'b0; r_oval <= 1'b0;
        end else begin
            if (o_take && i_verdict.status == tlssni_pkg::ST_FOUND) begin
                r_busy <= 1'b1;
            end else if (issue && last_rd) begin
                r_busy <= 1'b0;
            end
            if (issue) r_pend <= 1'b1;
            else if (move) r_pend <= 1'b0;
            if (move || (o_take && i_verdict.status != tlssni_pkg::ST_FOUND)) begin
                r_oval <= 1'b1;
            end else if (o_name.ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_bank <= i_verdict.bank;
            r_rem <= i_len;
            r_addr <= '0;
        end else if (issue) begin
            r_rem <= r_rem - LW'(rd_n);
            r_addr <= r_addr + AW'(1);
        end
        if (issue) begin
            r_rd_bytes <= rd_n;
            r_rd_last <= last_rd;
        end
        if (move) begin
            r_chunk <= masked; r_bytes <= r_rd_bytes;
            r_status <= tlssni_pkg::ST_FOUND; r_last <= r_rd_last;
        end else if (o_take && i_verdict.status != tlssni_pkg::ST_FOUND) begin
            r_chunk <= 64'd0; r_bytes <= 4'd0;
            r_status <= i_verdict.status; r_last <= 1'b1;
        end
    end

    assign o_name.valid = r_oval;
    assign o_name.name_chunk = r_chunk;
    assign o_name.chunk_bytes = r_bytes;
    assign o_name.status = r_status;
    assign o_name.last_chunk = r_last;

    `TLSSNI_ASSERT_NOW(a_found_has_bytes, r_oval && r_status == tlssni_pkg::ST_FOUND,
        r_bytes != 4'd0 && r_bytes <= 4'd8, "found chunk without bytes")
    `TLSSNI_ASSERT_NOW(a_fail_single, r_oval && r_status != tlssni_pkg::ST_FOUND,
        r_last && r_bytes == 4'd0, "failure transaction not single")
    `TLSSNI_ASSERT_NEXT(a_pend_holds, r_pend && !move, r_pend, "read word dropped")
    `TLSSNI_ASSERT_NOW(a_take_idle, o_take, !r_busy && !r_pend, "verdict taken while busy")
endmodule
`default_nettype wire

[hdl/tls_client_hello_sni_extractor.sv]
// Extracts the first valid SNI hostname from a TLS ClientHello, one packet byte per
// cycle. Every accepted byte is parsed in the same cycle, so input runs at one byte per
// clock. At the packet's last byte a verdict forms; with a name found, ceil(len/8)
// chunk transactions follow at one per ready cycle, read from a two-bank name store
// (one registered read per chunk), otherwise one failure transaction. Input stalls
// only while a finished verdict waits for the sender to finish the previous packet.
// depends on tlssni_pkg, tlssni_ifs, tlssni_parser, tlssni_name_ram, tlssni_emitter
`default_nettype none
module tls_client_hello_sni_extractor #(
    parameter int NAME_MAX = tlssni_pkg::NAME_MAX_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    tlssni_in_if.sink     i_byte,
    tlssni_out_if.source  o_name
);
    localparam int Words = (NAME_MAX + 7) / 8;
    localparam int AW    = (Words > 1) ? $clog2(Words) : 1;
    localparam int LW    = $clog2(NAME_MAX + 1);

    logic                 vld, take, we, re;
    tlssni_pkg::t_verdict verdict;
    logic [LW-1:0]        len;
    logic [AW:0]          waddr, raddr;
    logic [2:0]           wlane;
    logic [7:0]           wdata;
    logic [63:0]          rdata;

    // byte parser
    tlssni_parser #(.NAME_MAX(NAME_MAX), .AW(AW), .LW(LW)) u_parser (
        .i_clk, .i_rst_n, .i_byte,
        .i_take(take), .o_vld(vld), .o_verdict(verdict), .o_len(len),
        .o_we(we), .o_waddr(waddr), .o_wlane(wlane), .o_wdata(wdata)
    );

    // name store
    tlssni_name_ram #(.AW(AW)) u_ram (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wlane(wlane), .i_wdata(wdata),
        .i_re(re), .i_raddr(raddr), .o_rdata(rdata)
    );

    // result sender
    tlssni_emitter #(.AW(AW), .LW(LW)) u_emitter (
        .i_clk, .i_rst_n, .i_vld(vld), .i_verdict(verdict), .i_len(len),
        .o_take(take), .o_re(re), .o_raddr(raddr), .i_rdata(rdata), .o_name
    );
endmodule
`default_nettype wire

[dv/testbench.sv]
// self-checking testbench for the tls client hello sni extractor
// depends on tlssni_pkg, tlssni_ifs and the extractor rtl
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    localparam int NAME_LIMIT = tlssni_pkg::NAME_MAX_DEF;

    // flaws that the hello builder can put into a packet
    localparam int F_NONE      = 0;
    localparam int F_LIST_OVER = 1;
    localparam int F_NAME_OVER = 2;
    localparam int F_EXT_OVER  = 3;
    localparam int F_NO_SNI    = 4;
    localparam int F_SHORT_REC = 5;
    localparam int F_TRAIL     = 6;

    // entries placed in the server name list ahead of the real hostname
    localparam int PRE_NONE  = 0;
    localparam int PRE_BAD   = 1;
    localparam int PRE_OTHER = 2;
    localparam int PRE_EMPTY = 3;

    typedef enum logic [4:0] {
        P_REC_HDR, P_HS_HDR, P_FIXED, P_SID_LEN, P_SID_SKIP, P_CS_LEN, P_CS_SKIP,
        P_CM_LEN, P_CM_SKIP, P_EXTS_LEN, P_EXT_HDR, P_EXT_SKIP, P_LIST_LEN,
        P_ENTRY_HDR, P_NAME, P_ENTRY_SKIP, P_SNI_REST, P_DONE
    } t_phase;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_pkt_byte;

    typedef struct packed {
        logic [63:0] chunk;
        logic [3:0]  nbytes;
        logic [1:0]  status;
        logic        last;
    } t_name_chunk;

    logic i_clk;
    logic i_rst_n;

    tlssni_in_if  in_ch ();
    tlssni_out_if out_ch ();

    tls_client_hello_sni_extractor i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (in_ch),
        .o_name  (out_ch)
    );

    t_pkt_byte   pending_bytes[$];
    t_name_chunk expected_chunks[$];
    logic [7:0]  pkt_q[$];

    int err_count     = 0;
    int accepted_in   = 0;
    int total_bytes   = 0;
    int packet_count  = 0;
    int chunks_seen   = 0;
    int names_found   = 0;
    int hold_left     = 0;
    bit hold_done     = 0;

    // parser shadow state
    t_phase      ph;
    logic [15:0] seen, rec_len, frem, ext_rem, sni_rem, list_rem, nm_len, found_len;
    logic [31:0] body_len, body_off, fval;
    bit          chars_ok, failed, found, too_long;
    logic [7:0]  name_buf[NAME_LIMIT];

    // clock and reset
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n         = 0;
        in_ch.valid      = 0;
        in_ch.byte_value = 0;
        in_ch.last_byte  = 0;
        out_ch.ready     = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
    end

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    function automatic bit is_name_char(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z") || c == "-" || c == ".";
    endfunction

    function automatic void clear_state();
        ph = P_REC_HDR;
        seen = 0; rec_len = 0; body_len = 0; body_off = 0; fval = 0; frem = 0;
        ext_rem = 0; sni_rem = 0; list_rem = 0; nm_len = 0; found_len = 0;
        chars_ok = 1; failed = 0; found = 0; too_long = 0;
    endfunction

    function automatic void abort_parse();
        failed = 1;
        ph = P_DONE;
    endfunction

    function automatic void start_fld(t_phase p, logic [15:0] n);
        ph = p;
        frem = n;
        fval = 0;
    endfunction

    function automatic bit collect_byte(logic [7:0] b);
        fval = {fval[23:0], b};
        if (frem != 0) frem--;
        return frem == 0;
    endfunction

    function automatic bit count_dn();
        if (frem != 0) frem--;
        return frem == 0;
    endfunction

    function automatic void ext_loop();
        if (ext_rem >= 4) start_fld(P_EXT_HDR, 4);
        else ph = P_DONE;
    endfunction

    function automatic void sni_rest_or_ext();
        if (sni_rem > 0) ph = P_SNI_REST;
        else ext_loop();
    endfunction

    function automatic void sni_loop();
        if (sni_rem >= 3 && list_rem > 0) start_fld(P_ENTRY_HDR, 3);
        else sni_rest_or_ext();
    endfunction

    // advance the shadow parser by one byte; on the last byte queue the verdict
    task automatic parse_byte(logic [7:0] b, logic last);
        logic [15:0] idx, n, elen, nlen, s, pos, at;
        logic [7:0]  ntype;
        logic [63:0] chunk;
        bit          go, complete;
        idx = seen;
        go  = 1;
        if (ph >= P_FIXED && ph <= P_EXTS_LEN) begin
            if (body_off >= body_len) begin
                abort_parse();
                go = 0;
            end else begin
                body_off++;
            end
        end
        if (ph >= P_LIST_LEN && ph <= P_SNI_REST) begin
            if (sni_rem != 0) sni_rem--;
            if (list_rem != 0) list_rem--;
        end
        if (go) begin
            case (ph)
                P_REC_HDR: begin
                    if (idx == 0) begin
                        if (b != 22) abort_parse();
                    end else if (idx == 1) begin
                        if (b != 3) abort_parse();
                    end else if (idx == 2) begin
                        if (b > 4) abort_parse();
                    end else if (idx == 3) begin
                        rec_len = {b, 8'h00};
                    end else begin
                        rec_len = rec_len | {8'h00, b};
                        if (rec_len < 4 || rec_len > 16384) abort_parse();
                        else ph = P_HS_HDR;
                    end
                end
                P_HS_HDR: begin
                    if (idx == 5) begin
                        if (b != 1) abort_parse();
                    end else begin
                        body_len = {8'h00, body_len[15:0], b};
                        if (idx >= 8) begin
                            if (4 + body_len > rec_len || body_len < 34) begin
                                abort_parse();
                            end else begin
                                body_off = 0;
                                start_fld(P_FIXED, 34);
                            end
                        end
                    end
                end
                P_FIXED: if (count_dn()) ph = P_SID_LEN;
                P_SID_LEN: begin
                    start_fld(P_SID_SKIP, {8'h00, b});
                    if (b == 0) start_fld(P_CS_LEN, 2);
                end
                P_SID_SKIP: if (count_dn()) start_fld(P_CS_LEN, 2);
                P_CS_LEN: begin
                    if (collect_byte(b)) begin
                        n = fval[15:0];
                        start_fld(P_CS_SKIP, n);
                        if (n == 0) ph = P_CM_LEN;
                    end
                end
                P_CS_SKIP: if (count_dn()) ph = P_CM_LEN;
                P_CM_LEN: begin
                    start_fld(P_CM_SKIP, {8'h00, b});
                    if (b == 0) start_fld(P_EXTS_LEN, 2);
                end
                P_CM_SKIP: if (count_dn()) start_fld(P_EXTS_LEN, 2);
                P_EXTS_LEN: begin
                    if (collect_byte(b)) begin
                        n = fval[15:0];
                        if (body_off + n > body_len) begin
                            abort_parse();
                        end else begin
                            ext_rem = n;
                            ext_loop();
                        end
                    end
                end
                P_EXT_HDR: begin
                    if (collect_byte(b)) begin
                        elen    = fval[15:0];
                        ext_rem = ext_rem - 16'd4;
                        if (elen > ext_rem) begin
                            ph = P_DONE;
                        end else begin
                            ext_rem = ext_rem - elen;
                            if (fval[31:16] == 0) begin
                                sni_rem  = elen;
                                list_rem = 0;
                                if (elen >= 2) start_fld(P_LIST_LEN, 2);
                                else sni_rest_or_ext();
                            end else begin
                                start_fld(P_EXT_SKIP, elen);
                                if (elen == 0) ext_loop();
                            end
                        end
                    end
                end
                P_EXT_SKIP: if (count_dn()) ext_loop();
                P_LIST_LEN: begin
                    if (collect_byte(b)) begin
                        n = fval[15:0];
                        if (n > sni_rem) begin
                            sni_rest_or_ext();
                        end else begin
                            list_rem = n;
                            sni_loop();
                        end
                    end
                end
                P_ENTRY_HDR: begin
                    if (collect_byte(b)) begin
                        ntype = fval[23:16];
                        nlen  = fval[15:0];
                        if (ntype == 0) begin
                            if (nlen > sni_rem) begin
                                sni_rest_or_ext();
                            end else begin
                                nm_len   = nlen;
                                chars_ok = 1;
                                start_fld(P_NAME, nlen);
                                if (nlen == 0) sni_loop();
                            end
                        end else begin
                            s = (nlen < sni_rem) ? nlen : sni_rem;
                            start_fld(P_ENTRY_SKIP, s);
                            if (s == 0) sni_loop();
                        end
                    end
                end
                P_NAME: begin
                    pos = nm_len - frem;
                    if (!is_name_char(b)) chars_ok = 0;
                    if (pos < NAME_LIMIT)
                        name_buf[pos] = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
                    if (count_dn()) begin
                        if (chars_ok) begin
                            if (nm_len > NAME_LIMIT) begin
                                too_long = 1;
                            end else begin
                                found     = 1;
                                found_len = nm_len;
                            end
                            ph = P_DONE;
                        end else begin
                            sni_loop();
                        end
                    end
                end
                P_ENTRY_SKIP: if (count_dn()) sni_loop();
                P_SNI_REST: if (sni_rem == 0) ext_loop();
                default: ;
            endcase
        end
        if (seen < 32767) seen++;

        if (last) begin
            complete = !failed && (32'(seen) >= 32'd5 + 32'(rec_len));
            if (complete && found && found_len > 0) begin
                names_found++;
                for (pos = 0; pos < found_len; pos += 8) begin
                    chunk = 0;
                    n = (found_len - pos > 8) ? 16'd8 : found_len - pos;
                    for (int i = 0; i < n; i++) begin
                        at = pos + 16'(i);
                        chunk[8*i +: 8] = name_buf[at];
                    end
                    expected_chunks.push_back('{chunk, n[3:0], tlssni_pkg::ST_FOUND,
                                                pos + n >= found_len});
                end
            end else begin
                expected_chunks.push_back('{64'd0, 4'd0,
                    (complete && too_long) ? tlssni_pkg::ST_TOO_LONG : tlssni_pkg::ST_NONE,
                    1'b1});
            end
            clear_state();
        end
    endtask

    // ---------------------------------------------------------------- stimulus

    function automatic logic [7:0] rand_name_char();
        int r;
        r = $urandom_range(0, 63);
        if (r < 10) return 8'("0" + r);
        if (r < 36) return 8'("a" + r - 10);
        if (r < 62) return 8'("A" + r - 36);
        return (r == 62) ? 8'("-") : 8'(".");
    endfunction

    function automatic logic [7:0] rand_bad_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (is_name_char(c));
        return c;
    endfunction

    // build a client hello into pkt_q
    task automatic make_hello(int nlen, int pre, int flaw);
        logic [7:0] nm[$], ents[$], exts[$], body[$], hs[$];
        int n, list_len, rlen;
        for (int i = 0; i < nlen; i++) nm.push_back(rand_name_char());
        if ($urandom_range(0, 5) == 0 && nlen > 0 && pre == PRE_NONE)
            nm[$urandom_range(0, nlen - 1)] = rand_bad_char();
        case (pre)
            PRE_BAD:   ents = '{8'd0, 8'd0, 8'd3, 8'("a"), rand_bad_char(), 8'("b")};
            PRE_OTHER: ents = '{8'($urandom_range(1, 255)), 8'd0, 8'd2,
                               8'($urandom), 8'($urandom)};
            PRE_EMPTY: ents = '{8'd0, 8'd0, 8'd0};
            default:   ents = {};
        endcase
        n = (flaw == F_NAME_OVER) ? nlen + 50 : nlen;
        ents = {ents, 8'd0, 8'(n >> 8), 8'(n), nm};
        list_len = ents.size() + ((flaw == F_LIST_OVER) ? 20 : 0);
        // a few ordinary extensions ahead of server_name
        for (int k = $urandom_range(0, 2); k > 0; k--) begin
            n = $urandom_range(0, 6);
            exts = {exts, 8'h00, 8'($urandom_range(1, 255)), 8'h00,
                    8'((flaw == F_EXT_OVER) ? n + 100 : n)};
            for (int i = 0; i < n; i++) exts.push_back(8'($urandom));
        end
        if (flaw != F_NO_SNI) begin
            n = ents.size() + 2;
            exts = {exts, 8'h00, 8'h00, 8'(n >> 8), 8'(n), 8'(list_len >> 8),
                    8'(list_len), ents};
        end
        for (int i = 0; i < 34; i++) body.push_back(8'($urandom));
        n = $urandom_range(0, 3) * 8;
        body.push_back(8'(n));
        for (int i = 0; i < n; i++) body.push_back(8'($urandom));
        n = $urandom_range(1, 4) * 2;
        body = {body, 8'h00, 8'(n)};
        for (int i = 0; i < n; i++) body.push_back(8'($urandom));
        n = $urandom_range(1, 2);
        body.push_back(8'(n));
        for (int i = 0; i < n; i++) body.push_back(8'($urandom));
        body = {body, 8'(exts.size() >> 8), 8'(exts.size()), exts};
        hs = {8'd1, 8'(body.size() >> 16), 8'(body.size() >> 8), 8'(body.size()), body};
        rlen = hs.size() + ((flaw == F_SHORT_REC) ? 10 : 0);
        pkt_q = {8'd22, 8'd3, 8'($urandom_range(0, 4)), 8'(rlen >> 8), 8'(rlen), hs};
        if (flaw == F_TRAIL)
            for (int i = $urandom_range(1, 6); i > 0; i--) pkt_q.push_back(8'($urandom));
    endtask

    task automatic queue_packet();
        foreach (pkt_q[i]) pending_bytes.push_back('{pkt_q[i], i == pkt_q.size() - 1});
        total_bytes += pkt_q.size();
        packet_count++;
    endtask

    // header check cases: a hello cut after the handshake length, with one or two bytes patched
    task automatic hello_patched(int at, logic [7:0] v, int at2, logic [7:0] v2);
        make_hello(6, PRE_NONE, F_NONE);
        pkt_q[at] = v;
        pkt_q[at2] = v2;
        pkt_q = pkt_q[0:8];
        queue_packet();
    endtask

    task automatic fill_stimulus();
        int r, k;
        // directed: header checks, the longest name and a few list special cases
        pkt_q = '{8'd22};                      queue_packet();
        hello_patched(0, 8'd20, 0, 8'd20);
        hello_patched(1, 8'd2, 1, 8'd2);
        hello_patched(2, 8'd5, 2, 8'd5);
        hello_patched(3, 8'h00, 4, 8'h00);
        hello_patched(3, 8'h40, 4, 8'h01);
        hello_patched(5, 8'd2, 5, 8'd2);
        hello_patched(6, 8'd0, 8, 8'd20);
        make_hello(NAME_LIMIT, PRE_EMPTY, F_NONE); queue_packet();
        make_hello(3, PRE_BAD, F_TRAIL);          queue_packet();
        make_hello(2, PRE_OTHER, F_SHORT_REC);    queue_packet();

        // random top-up: mostly well-formed hellos, some corrupted, some noise
        while (total_bytes < 460) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                make_hello($urandom_range(1, 24),
                           $urandom_range(0, 1) ? $urandom_range(0, 3) : PRE_NONE,
                           ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : F_NONE);
            end else if (r < 85) begin
                make_hello($urandom_range(1, 16), PRE_NONE, F_NONE);
                k = $urandom_range(0, pkt_q.size() - 1);
                if ($urandom_range(0, 1)) pkt_q = pkt_q[0:k];
                else pkt_q[k] = 8'($urandom);
            end else begin
                pkt_q = {};
                if ($urandom_range(0, 1)) pkt_q = '{8'd22, 8'd3};
                for (k = $urandom_range(1, 12); k > 0; k--) pkt_q.push_back(8'($urandom));
            end
            queue_packet();
        end
    endtask

    // ---------------------------------------------------------------- driver

    function automatic int send_idle_pct();
        if (accepted_in < total_bytes / 3) return 23;
        if (accepted_in < 2 * total_bytes / 3) return 59;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (accepted_in < total_bytes / 3) return 59;
        if (accepted_in < 2 * total_bytes / 3) return 23;
        return 0;
    endfunction

    // byte source; predicts on every accepted transaction
    always @(posedge i_clk) begin
        t_pkt_byte nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                parse_byte(in_ch.byte_value, in_ch.last_byte);
                accepted_in++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
                    nxt = pending_bytes.pop_front();
                    in_ch.valid      <= 1;
                    in_ch.byte_value <= nxt.value;
                    in_ch.last_byte  <= nxt.last;
                end else begin
                    in_ch.valid <= 0;
                end
            end
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    always @(posedge i_clk) begin
        if (!hold_done && accepted_in >= 20) begin
            hold_left <= 400;
            hold_done <= 1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 0;
        else out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct());
    end

    // ---------------------------------------------------------------- monitor

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %h, want %h", $realtime, what, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_name_chunk e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            chunks_seen++;
            if (expected_chunks.size() == 0) begin
                report_mismatch("unexpected transaction", out_ch.name_chunk, 0);
            end else begin
                e = expected_chunks.pop_front();
                if (out_ch.name_chunk !== e.chunk)
                    report_mismatch("name_chunk", out_ch.name_chunk, e.chunk);
                if (out_ch.chunk_bytes !== e.nbytes)
                    report_mismatch("chunk_bytes", 64'(out_ch.chunk_bytes), 64'(e.nbytes));
                if (out_ch.status !== e.status)
                    report_mismatch("status", 64'(out_ch.status), 64'(e.status));
                if (out_ch.last_chunk !== e.last)
                    report_mismatch("last_chunk", 64'(out_ch.last_chunk), 64'(e.last));
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        clear_state();
        foreach (name_buf[i]) name_buf[i] = 0;
        fill_stimulus();
        @(posedge i_clk iff i_rst_n);
        while (pending_bytes.size() > 0 || in_ch.valid) @(posedge i_clk);
        while (expected_chunks.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        foreach (expected_chunks[i])
            report_mismatch("missing transaction", 0, expected_chunks[i].chunk);
        $display("run covered %0d packets (%0d bytes) and %0d chunk transactions, %0d names",
                 packet_count, total_bytes, chunks_seen, names_found);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
